// File: sv/bsst_pkg.sv
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types, constants and helpers of the body sleep state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bsst_pkg;

	localparam int DATA_W         = 32;
	localparam int IDX_W          = 6;
	localparam int DT_W           = 16;
	localparam int ALPHA_W        = 16;
	localparam int NUM_BODIES_DEF = 64;

	// 0.1 s in Q1.16
	localparam logic [DT_W:0] TAU_Q16 = 17'd6554;
	localparam logic [DT_W-1:0] STEP_DT_RST = 16'd1092;

	// divider pipeline shape: 8 stages x 4 weight steps, 8 x 2 alpha steps
	localparam int DIV_STAGES = 8;
	localparam int W_STEPS    = 4;
	localparam int A_STEPS    = 2;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_WAKE  = 2'd1,
		ACT_SLEEP = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		BAND_MOVING = 2'd0,
		BAND_HYST   = 2'd1,
		BAND_QUIET  = 2'd2,
		BAND_SKIP   = 2'd3
	} band_t;

	// one item as it travels down the pipeline
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              oor;
		logic              skip;
		logic              wake;
		logic              wsat;
		logic              wzero;
		logic [DT_W-1:0]   dt;
		logic [DATA_W-1:0] lin_sq;
		logic [DATA_W-1:0] ang_sq;
		logic [DATA_W-1:0] inv_m;
		logic [DATA_W-1:0] inv_i;
		logic [DATA_W-1:0] lin_thr;
		logic [DATA_W-1:0] ang_thr;
		logic [DATA_W-1:0] time_thr;
	} item_t;

	function automatic logic [DATA_W-1:0] sat32(input logic [63:0] v);
		sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/bsst_if.sv
// ----------------------------------------------------------------------------
// bsst_if
// Channel interfaces: per-body motion summary in, sleep verdict out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsst_motion_if;
	logic        valid;
	logic        ready;
	logic [5:0]  body_index;
	logic        is_dynamic;
	logic        has_move_target;
	logic [31:0] force_sq;
	logic [31:0] torque_sq;
	logic [31:0] lin_speed_sq;
	logic [31:0] ang_speed_sq;
	logic [31:0] inv_mass;
	logic [31:0] inv_inertia;
	logic [31:0] lin_threshold;
	logic [31:0] ang_threshold;
	logic [31:0] time_threshold;

	modport source (output valid, body_index, is_dynamic, has_move_target, force_sq,
		torque_sq, lin_speed_sq, ang_speed_sq, inv_mass, inv_inertia, lin_threshold,
		ang_threshold, time_threshold, input ready);
	modport sink (input valid, body_index, is_dynamic, has_move_target, force_sq,
		torque_sq, lin_speed_sq, ang_speed_sq, inv_mass, inv_inertia, lin_threshold,
		ang_threshold, time_threshold, output ready);
endinterface

interface bsst_verdict_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  band;
	logic [31:0] smoothed_energy;
	logic [31:0] quiet_time;

	modport source (output valid, action, band, smoothed_energy, quiet_time, input ready);
	modport sink (input valid, action, band, smoothed_energy, quiet_time, output ready);
endinterface

`default_nettype wire

// File: sv/bsst_div.sv
// ----------------------------------------------------------------------------
// bsst_div
// Pipelined restoring dividers: mass/inertia weight and smoothing alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire bsst_pkg::item_t in_item,
	output logic                 out_valid,
	output bsst_pkg::item_t      out_item,
	output logic [31:0]          out_weight,
	output logic [15:0]          out_alpha
);

	localparam int DS = bsst_pkg::DIV_STAGES;

	logic            vld_s [0:DS];
	bsst_pkg::item_t itm_s [0:DS];
	logic [31:0]     rw_s  [0:DS];
	logic [31:0]     qw_s  [0:DS];
	logic [31:0]     nb_s  [0:DS];
	logic [16:0]     ra_s  [0:DS];
	logic [15:0]     qa_s  [0:DS];

	// stage 0: initial remainders (top dividend bits already below divisor)
	always_comb begin
		vld_s[0] = in_valid;
		itm_s[0] = in_item;
		rw_s[0]  = {16'd0, in_item.inv_m[31:16]};
		qw_s[0]  = 32'd0;
		nb_s[0]  = {in_item.inv_m[15:0], 16'd0};
		ra_s[0]  = {1'b0, in_item.dt};
		qa_s[0]  = 16'd0;
	end

	for (genvar k = 1; k <= DS; k++) begin : g_stage
		logic [31:0] rw, qw, nb;
		logic [16:0] ra, da;
		logic [15:0] qa;
		logic [32:0] tw;
		logic [17:0] ta;

		// a few restoring steps per stage on each lane
		always_comb begin
			rw = rw_s[k-1];
			qw = qw_s[k-1];
			nb = nb_s[k-1];
			ra = ra_s[k-1];
			qa = qa_s[k-1];
			da = bsst_pkg::TAU_Q16 + {1'b0, itm_s[k-1].dt};
			tw = 33'd0;
			ta = 18'd0;
			for (int j = 0; j < bsst_pkg::W_STEPS; j++) begin
				tw = {rw, nb[31]};
				nb = {nb[30:0], 1'b0};
				if (tw >= {1'b0, itm_s[k-1].inv_i}) begin
					rw = 32'(tw - {1'b0, itm_s[k-1].inv_i});
					qw = {qw[30:0], 1'b1};
				end else begin
					rw = tw[31:0];
					qw = {qw[30:0], 1'b0};
				end
			end
			for (int j = 0; j < bsst_pkg::A_STEPS; j++) begin
				ta = {ra, 1'b0};
				if (ta >= {1'b0, da}) begin
					ra = 17'(ta - {1'b0, da});
					qa = {qa[14:0], 1'b1};
				end else begin
					ra = ta[16:0];
					qa = {qa[14:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k] <= itm_s[k-1];
				rw_s[k]  <= rw;
				qw_s[k]  <= qw;
				nb_s[k]  <= nb;
				ra_s[k]  <= ra;
				qa_s[k]  <= qa;
			end
		end
	end

	assign out_valid  = vld_s[DS];
	assign out_item   = itm_s[DS];
	assign out_weight = qw_s[DS];
	assign out_alpha  = qa_s[DS];

endmodule

`default_nettype wire

// File: sv/bsst_energy.sv
// ----------------------------------------------------------------------------
// bsst_energy
// Energy proxy, alpha-weighted energy term and enter threshold, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_energy (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire bsst_pkg::item_t in_item,
	input  wire logic [31:0]     in_weight,
	input  wire logic [15:0]     in_alpha,
	output logic                 out_valid,
	output bsst_pkg::item_t      out_item,
	output logic [15:0]          out_alpha,
	output logic [47:0]          out_pe,
	output logic [31:0]          out_enter
);

	logic [31:0]     weight;
	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	bsst_pkg::item_t itm_s1, itm_s2, itm_s3, itm_s4;
	logic [15:0]     alpha_s1, alpha_s2, alpha_s3, alpha_s4;
	logic [31:0]     w_s1, w_s2;
	logic [63:0]     pang_s1, plin_s1, pathr_s1;
	logic [31:0]     energy_s2, linq_s2, angq_s2;
	logic [47:0]     pe_s3, pe_s4;
	logic [63:0]     pw_s3;
	logic [31:0]     linq_s3, enter_s4;

	// saturate / zero the divider quotient
	always_comb begin
		if (in_item.wzero) begin
			weight = 32'd0;
		end else if (in_item.wsat) begin
			weight = 32'hFFFF_FFFF;
		end else begin
			weight = in_weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: raw products
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1   <= in_item;
			alpha_s1 <= in_alpha;
			w_s1     <= weight;
			pang_s1  <= {32'd0, weight} * {32'd0, in_item.ang_sq};
			plin_s1  <= {32'd0, in_item.lin_thr} * {32'd0, in_item.lin_thr};
			pathr_s1 <= {32'd0, in_item.ang_thr} * {32'd0, in_item.ang_thr};
		end
	end

	// stage 2: energy proxy and squared thresholds
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s2    <= itm_s1;
			alpha_s2  <= alpha_s1;
			w_s2      <= w_s1;
			energy_s2 <= bsst_pkg::sat32(64'(itm_s1.lin_sq)
				+ 64'(bsst_pkg::sat32({16'd0, pang_s1[63:16]})));
			linq_s2   <= bsst_pkg::sat32({16'd0, plin_s1[63:16]});
			angq_s2   <= bsst_pkg::sat32({16'd0, pathr_s1[63:16]});
		end
	end

	// stage 3: alpha * energy, weight * squared angular threshold
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s3   <= itm_s2;
			alpha_s3 <= alpha_s2;
			pe_s3    <= 48'(alpha_s2) * 48'(energy_s2);
			pw_s3    <= {32'd0, w_s2} * {32'd0, angq_s2};
			linq_s3  <= linq_s2;
		end
	end

	// stage 4: enter threshold
	always_ff @(posedge clk) begin
		if (en) begin
			itm_s4   <= itm_s3;
			alpha_s4 <= alpha_s3;
			pe_s4    <= pe_s3;
			enter_s4 <= bsst_pkg::sat32(64'(linq_s3)
				+ 64'(bsst_pkg::sat32({16'd0, pw_s3[63:16]})));
		end
	end

	assign out_valid = vld_s4;
	assign out_item  = itm_s4;
	assign out_alpha = alpha_s4;
	assign out_pe    = pe_s4;
	assign out_enter = enter_s4;

endmodule

`default_nettype wire

// File: sv/bsst_state.sv
// ----------------------------------------------------------------------------
// bsst_state
// Per-body average and quiet timer tables, hysteresis decision, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module bsst_state #(
	parameter int NUM_BODIES = bsst_pkg::NUM_BODIES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire bsst_pkg::item_t in_item,
	input  wire logic [15:0]     in_alpha,
	input  wire logic [47:0]     in_pe,
	input  wire logic [31:0]     in_enter,
	output logic                 clr_busy,
	output logic                 out_valid,
	output logic [1:0]           out_action,
	output logic [1:0]           out_band,
	output logic [31:0]          out_energy,
	output logic [31:0]          out_time
);

	localparam int AW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

	logic [31:0] avg_mem [0:NUM_BODIES-1];
	logic [31:0] tmr_mem [0:NUM_BODIES-1];

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic [31:0]     idx_in_ext, idx_s1_ext;
	logic [AW-1:0]   addr_in;
	logic            vld_s1, vld_s2, vld_s3;
	bsst_pkg::item_t itm_s1;
	logic [AW-1:0]   addr_s1, addr_s2;
	logic [15:0]     alpha_s1;
	logic [47:0]     pe_s1;
	logic [31:0]     enter_s1, enter_s2;
	logic [31:0]     avg_rd_s1;
	logic            upd_s1, upd_s2;
	logic [48:0]     prod;
	logic [49:0]     mix;
	logic [31:0]     avg_new, avg_w;
	logic            oor_s2, wake_s2;
	logic [15:0]     dt_s2;
	logic [31:0]     tthr_s2, avg_s2, tmr_rd_s2;
	logic [31:0]     upper, tmr_sum, tmr_new, e_out, t_out;
	logic            tmr_wr;
	bsst_pkg::action_t act;
	bsst_pkg::band_t   band;
	logic [1:0]      act_s3, band_s3;
	logic [31:0]     energy_s3, time_s3;

	assign idx_in_ext = 32'(in_item.idx);
	assign idx_s1_ext = 32'(itm_s1.idx);
	assign addr_in    = idx_in_ext[AW-1:0];

	// clearing pass after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(NUM_BODIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end
	assign clr_busy = clr_busy_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: average update (read-modify-write with bypass)
	assign upd_s1 = vld_s1 && !itm_s1.oor && !itm_s1.skip && !itm_s1.wake;

	always_comb begin
		prod    = 49'(17'd65536 - {1'b0, alpha_s1}) * 49'(avg_rd_s1);
		mix     = 50'(prod) + 50'(pe_s1) + 50'd32768;
		avg_new = bsst_pkg::sat32(64'(mix[49:16]));
		avg_w   = upd_s1 ? avg_new : avg_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			avg_mem[clr_addr_q] <= 32'd0;
		end else if (en && upd_s1) begin
			avg_mem[addr_s1] <= avg_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1   <= in_item;
			addr_s1  <= addr_in;
			alpha_s1 <= in_alpha;
			pe_s1    <= in_pe;
			enter_s1 <= in_enter;
			if (upd_s1 && addr_s1 == addr_in) begin
				avg_rd_s1 <= avg_new;
			end else begin
				avg_rd_s1 <= avg_mem[addr_in];
			end
		end
	end

	// stage 2: hysteresis and quiet timer (read-modify-write with bypass)
	always_comb begin
		upper   = bsst_pkg::sat32({30'd0, enter_s2, 2'b00});
		tmr_sum = bsst_pkg::sat32(64'(tmr_rd_s2) + 64'(dt_s2));
		act     = bsst_pkg::ACT_NONE;
		band    = bsst_pkg::BAND_SKIP;
		e_out   = avg_s2;
		t_out   = tmr_rd_s2;
		tmr_new = tmr_rd_s2;
		tmr_wr  = 1'b0;
		if (oor_s2) begin
			e_out = 32'd0;
			t_out = 32'd0;
		end else if (!upd_s2) begin
			if (wake_s2) begin
				act = bsst_pkg::ACT_WAKE;
			end
		end else if (avg_s2 > upper) begin
			band    = bsst_pkg::BAND_MOVING;
			tmr_new = 32'd0;
			t_out   = 32'd0;
			tmr_wr  = 1'b1;
		end else if (avg_s2 > enter_s2) begin
			band = bsst_pkg::BAND_HYST;
		end else begin
			band    = bsst_pkg::BAND_QUIET;
			tmr_new = tmr_sum;
			t_out   = tmr_sum;
			tmr_wr  = 1'b1;
			if (tmr_sum >= tthr_s2) begin
				act = bsst_pkg::ACT_SLEEP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			tmr_mem[clr_addr_q] <= 32'd0;
		end else if (en && vld_s2 && tmr_wr) begin
			tmr_mem[addr_s2] <= tmr_new;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upd_s2   <= upd_s1;
			oor_s2   <= itm_s1.oor;
			wake_s2  <= itm_s1.wake;
			dt_s2    <= itm_s1.dt;
			tthr_s2  <= itm_s1.time_thr;
			addr_s2  <= addr_s1;
			avg_s2   <= avg_w;
			enter_s2 <= enter_s1;
			if (vld_s2 && tmr_wr && addr_s2 == addr_s1) begin
				tmr_rd_s2 <= tmr_new;
			end else begin
				tmr_rd_s2 <= tmr_mem[addr_s1];
			end
		end
	end

	// stage 3: result register
	always_ff @(posedge clk) begin
		if (en) begin
			act_s3    <= act;
			band_s3   <= band;
			energy_s3 <= e_out;
			time_s3   <= t_out;
		end
	end

	assign out_valid  = vld_s3;
	assign out_action = act_s3;
	assign out_band   = band_s3;
	assign out_energy = energy_s3;
	assign out_time   = time_s3;

	// index bits above the table depth only matter through the range flag
	logic unused_idx;
	assign unused_idx = ^idx_s1_ext;

endmodule

`default_nettype wire

// File: sv/body_sleep_state_tracker.sv
// ----------------------------------------------------------------------------
// body_sleep_state_tracker
// Per-body sleep detector: smoothed energy proxy with hysteresis and timer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  motion    in   valid / ready    one body's motion summary
//  verdict   out  valid / ready    action, band, average, quiet timer
//  cfg       in   cfg_we           step_dt (16 bits)
//
//  One transaction per cycle sustained while verdict is ready; the path is the
//  input register, 8 divider stages for the weight and alpha quotients,
//  4 energy stages and 3 table/decision/result stages.
//  After reset both tables are swept to zero, one entry a cycle, with
//  motion.ready low.
//  A stall on verdict freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module body_sleep_state_tracker #(
	parameter int NUM_BODIES = bsst_pkg::NUM_BODIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	bsst_motion_if.sink      motion,
	bsst_verdict_if.source   verdict
);

	logic [15:0]     step_dt_q;
	logic            en;
	logic            clr_busy;
	bsst_pkg::item_t item;
	logic            vld_s1;
	bsst_pkg::item_t itm_s1;
	logic            dv_valid, en_valid;
	bsst_pkg::item_t dv_item, en_item;
	logic [31:0]     dv_weight, en_enter;
	logic [15:0]     dv_alpha, en_alpha;
	logic [47:0]     en_pe;

	// step length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_dt_q <= bsst_pkg::STEP_DT_RST;
		end else if (cfg_we) begin
			step_dt_q <= cfg_wdata;
		end
	end

	// global advance: the result register is free or being drained
	assign en           = !verdict.valid || verdict.ready;
	assign motion.ready = en && !clr_busy;

	// classify the incoming transaction
	always_comb begin
		item.idx      = motion.body_index;
		item.oor      = 32'(motion.body_index) >= 32'(NUM_BODIES);
		item.skip     = !motion.is_dynamic;
		item.wake     = motion.is_dynamic && (motion.has_move_target
			|| motion.force_sq != 32'd0 || motion.torque_sq != 32'd0);
		item.wsat     = {16'd0, motion.inv_mass[31:16]} >= motion.inv_inertia;
		item.wzero    = motion.inv_mass == 32'd0 || motion.inv_inertia == 32'd0;
		item.dt       = step_dt_q;
		item.lin_sq   = motion.lin_speed_sq;
		item.ang_sq   = motion.ang_speed_sq;
		item.inv_m    = motion.inv_mass;
		item.inv_i    = motion.inv_inertia;
		item.lin_thr  = motion.lin_threshold;
		item.ang_thr  = motion.ang_threshold;
		item.time_thr = motion.time_threshold;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= motion.valid && motion.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1 <= item;
		end
	end

	bsst_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (vld_s1),
		.in_item    (itm_s1),
		.out_valid  (dv_valid),
		.out_item   (dv_item),
		.out_weight (dv_weight),
		.out_alpha  (dv_alpha)
	);

	bsst_energy u_energy (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (dv_valid),
		.in_item    (dv_item),
		.in_weight  (dv_weight),
		.in_alpha   (dv_alpha),
		.out_valid  (en_valid),
		.out_item   (en_item),
		.out_alpha  (en_alpha),
		.out_pe     (en_pe),
		.out_enter  (en_enter)
	);

	bsst_state #(
		.NUM_BODIES (NUM_BODIES)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (en_valid),
		.in_item    (en_item),
		.in_alpha   (en_alpha),
		.in_pe      (en_pe),
		.in_enter   (en_enter),
		.clr_busy   (clr_busy),
		.out_valid  (verdict.valid),
		.out_action (verdict.action),
		.out_band   (verdict.band),
		.out_energy (verdict.smoothed_energy),
		.out_time   (verdict.quiet_time)
	);

endmodule

`default_nettype wire
